### src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check that is held off while reset is active.
`define PLI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked property check that is also evaluated during reset.
`define PLI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### src/pli_pkg.sv
package pli_pkg;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOCATE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Widths wide enough for any supported capacity (up to 4096 entries).
    localparam int PLI_CNTW = 13;

    // Cells are reduced in groups of eight.
    localparam int GSIZE = 8;
    localparam int GIDXW = 3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [6:0]         found_position;
        logic [6:0]         current_length;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } t_cell_op;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op              op;
        logic [PLI_CNTW-1:0]   idx;   // zero-based target position
        logic [PLI_CNTW-1:0]   cnt;   // list length before the operation
    } t_cell_cmd;

endpackage

### src/pli_cell.sv
module pli_cell #(
    parameter int INDEX = 0,
    parameter int EW    = 32
) (
    input  logic               i_clk,
    input  pli_pkg::t_cell_cmd i_cmd,
    input  logic [EW-1:0]      i_prev,
    input  logic [EW-1:0]      i_next,
    input  logic [EW-1:0]      i_val,
    output logic [EW-1:0]      o_data,
    output logic               o_hit,
    output logic               o_sel
);
    import pli_pkg::*;

    localparam logic [PLI_CNTW-1:0] MY_IDX = PLI_CNTW'(INDEX);

    logic [EW-1:0] r_data;
    logic [EW-1:0] n_data;

    // Shift from the lower neighbor on insert, from the upper one on delete.
    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            OP_INSERT: begin
                if (MY_IDX == i_cmd.idx) begin
                    n_data = i_val;
                end else if (MY_IDX > i_cmd.idx && MY_IDX <= i_cmd.cnt) begin
                    n_data = i_prev;
                end
            end
            OP_DELETE: begin
                if (MY_IDX >= i_cmd.idx && (MY_IDX + PLI_CNTW'(1)) < i_cmd.cnt) begin
                    n_data = i_next;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Local match and select flags for the reduction tree.
    assign o_data = r_data;
    assign o_hit  = (r_data == i_val) && (MY_IDX < i_cmd.cnt);
    assign o_sel  = (MY_IDX == i_cmd.idx);

endmodule

### src/pli_group.sv
module pli_group #(
    parameter int EW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic [pli_pkg::GSIZE-1:0] i_hit,
    input  logic [pli_pkg::GSIZE-1:0] i_sel,
    input  logic [EW-1:0]             i_data [pli_pkg::GSIZE],
    output logic                      o_hit,
    output logic [pli_pkg::GIDXW-1:0] o_idx,
    output logic [EW-1:0]             o_data
);
    import pli_pkg::*;

    logic              r_hit;
    logic [GIDXW-1:0]  r_idx;
    logic [EW-1:0]     r_data;
    logic              n_hit;
    logic [GIDXW-1:0]  n_idx;
    logic [EW-1:0]     n_data;

    // First matching cell of the group, and the data of the selected cell.
    always_comb begin
        n_hit  = 1'b0;
        n_idx  = '0;
        n_data = '0;
        for (int k = GSIZE - 1; k >= 0; k--) begin
            if (i_hit[k]) begin
                n_hit = 1'b1;
                n_idx = GIDXW'(k);
            end
            n_data = n_data | (i_data[k] & {EW{i_sel[k]}});
        end
    end

    // The partial result is captured once per item and held until read.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hit  <= n_hit;
            r_idx  <= n_idx;
            r_data <= n_data;
        end
    end

    assign o_hit  = r_hit;
    assign o_idx  = r_idx;
    assign o_data = r_data;

endmodule

### src/positional_list_insert_delete_search.sv
// Ordered list of up to CAPACITY elements held in a chain of register cells,
// each cell holding one entry and taking data from its lower or upper neighbor
// when an insert or delete shifts the list. An item is accepted in the idle
// state; in the execute state the cells shift or take the new entry as needed
// and each group of eight cells registers its first match and selected entry;
// the gather state picks the first matching group and loads the output
// register once the output side does not stall. The next item is accepted
// only after the result sits in the output register, so no item is taken while
// one is in progress. Entries need no clearing; reset sets the length to zero.
module positional_list_insert_delete_search #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pli_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pli_pkg::t_out_item o_out_item
);
    import pli_pkg::*;

    localparam int EW    = ELEMENT_WIDTH;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NG    = (CAPACITY + GSIZE - 1) / GSIZE;
    localparam int NCELL = NG * GSIZE;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_GATHER = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [1:0]    r_kind;
    logic [6:0]    r_pos;
    logic [31:0]   r_val;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_item     r_out;
    t_out_item     n_out;

    logic [EW-1:0]       w_val;
    logic [PLI_CNTW-1:0] w_pos_ext;
    logic [PLI_CNTW-1:0] w_cnt_ext;
    t_cell_cmd           w_cmd;
    logic                w_in_acc;
    logic                w_out_load;

    logic [EW-1:0]    w_data [NCELL];
    logic [NCELL-1:0] w_hit;
    logic [NCELL-1:0] w_sel;

    logic             w_ghit  [NG];
    logic [GIDXW-1:0] w_gidx  [NG];
    logic [EW-1:0]    w_gdata [NG];

    logic          w_found;
    logic [AW:0]   w_first;
    logic [EW-1:0] w_removed;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_load = (r_state == S_GATHER) && (!r_out_valid || !i_out_stall);

    assign w_val     = EW'(r_val);
    assign w_pos_ext = PLI_CNTW'(r_pos);
    assign w_cnt_ext = PLI_CNTW'(r_count);

    // Request check and the shift command for the cells.
    always_comb begin
        n_status  = STATUS_DONE;
        n_count   = r_count;
        w_cmd.op  = OP_HOLD;
        w_cmd.idx = w_pos_ext - PLI_CNTW'(1);
        w_cmd.cnt = w_cnt_ext;
        case (r_kind)
            KIND_INSERT: begin
                if (r_pos == 7'd0 || w_pos_ext > (w_cnt_ext + PLI_CNTW'(1))) begin
                    n_status = STATUS_RANGE;
                end else if (w_cnt_ext >= PLI_CNTW'(CAPACITY)) begin
                    n_status = STATUS_FULL;
                end else begin
                    w_cmd.op = OP_INSERT;
                    n_count  = r_count + CW'(1);
                end
            end
            KIND_DELETE: begin
                if (r_pos == 7'd0 || w_pos_ext > w_cnt_ext) begin
                    n_status = STATUS_RANGE;
                end else begin
                    w_cmd.op = OP_DELETE;
                    n_count  = r_count - CW'(1);
                end
            end
            default: n_status = STATUS_DONE;
        endcase
        if (r_state != S_EXEC) begin
            w_cmd.op = OP_HOLD;
        end
    end

    // Chain of entry cells, padded to whole groups.
    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        if (j < CAPACITY) begin : g_real
            logic [EW-1:0] w_prev;
            logic [EW-1:0] w_next;
            if (j == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_link_lo
                assign w_prev = w_data[j-1];
            end
            if (j == CAPACITY - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_link_hi
                assign w_next = w_data[j+1];
            end
            pli_cell #(
                .INDEX (j),
                .EW    (EW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_cmd  (w_cmd),
                .i_prev (w_prev),
                .i_next (w_next),
                .i_val  (w_val),
                .o_data (w_data[j]),
                .o_hit  (w_hit[j]),
                .o_sel  (w_sel[j])
            );
        end else begin : g_pad
            assign w_data[j] = '0;
            assign w_hit[j]  = 1'b0;
            assign w_sel[j]  = 1'b0;
        end
    end

    // First level of the reduction: one register stage per group of cells.
    for (genvar g = 0; g < NG; g++) begin : g_grp
        logic [EW-1:0] w_gin [GSIZE];
        for (genvar k = 0; k < GSIZE; k++) begin : g_in
            assign w_gin[k] = w_data[g*GSIZE + k];
        end
        pli_group #(
            .EW (EW)
        ) u_group (
            .i_clk  (i_clk),
            .i_load (r_state == S_EXEC),
            .i_hit  (w_hit[g*GSIZE +: GSIZE]),
            .i_sel  (w_sel[g*GSIZE +: GSIZE]),
            .i_data (w_gin),
            .o_hit  (w_ghit[g]),
            .o_idx  (w_gidx[g]),
            .o_data (w_gdata[g])
        );
    end

    // Second level: first matching group and the selected entry.
    always_comb begin
        w_found   = 1'b0;
        w_first   = '0;
        w_removed = '0;
        for (int g = 0; g < NG; g++) begin
            if (!w_found && w_ghit[g]) begin
                w_found = 1'b1;
                w_first = (AW+1)'(g * GSIZE + int'(w_gidx[g]));
            end
            w_removed = w_removed | w_gdata[g];
        end
    end

    // Result item.
    always_comb begin
        n_out.status         = r_status;
        n_out.removed_value  = '0;
        n_out.found_position = '0;
        n_out.current_length = 7'(r_count);
        if (r_kind == KIND_DELETE && r_status == STATUS_DONE) begin
            n_out.removed_value = $signed(32'(w_removed));
        end
        if (r_kind == KIND_LOCATE && w_found) begin
            n_out.found_position = 7'(w_first + (AW+1)'(1));
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_EXEC;
            S_EXEC:   n_state = S_GATHER;
            S_GATHER: if (w_out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count <= n_count;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= i_in_item.kind;
            r_pos  <= i_in_item.position;
            r_val  <= $unsigned(i_in_item.value);
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`include "assert_macros.svh"

    `PLI_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "list length beyond capacity")
    `PLI_ASSERT(a_accept_exec, w_in_acc |=> r_state == S_EXEC, "accepted item not executed")
    `PLI_ASSERT(a_count_change, $past(i_rst_n) && r_count != $past(r_count) |-> $past(r_state) == S_EXEC, "length changed outside execute")
    `PLI_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> r_state == S_IDLE && !r_out_valid, "not idle after reset")

endmodule
